// File: rtl/core/rgbled_pkg.sv
// Shared types and constants for the RGB LED pattern generator.
`timescale 1ns / 1ps

package rgbled_pkg;

    // Field widths
    localparam int unsigned LEVEL_W  = 8;
    localparam int unsigned COLOR_W  = 24;
    localparam int unsigned MS_W     = 16;
    localparam int unsigned HUE_W    = 9;
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = COLOR_W;

    // Pattern constants
    localparam logic [MS_W-1:0]    DEFAULT_HALF_MS = MS_W'(300);
    localparam logic [MS_W-1:0]    RESET_STEP_MS   = MS_W'(20);
    localparam logic [HUE_W-1:0]   HUE_LAST        = HUE_W'(359);
    localparam logic [HUE_W-1:0]   HUE_SECTOR      = HUE_W'(60);
    localparam logic [LEVEL_W-1:0] FULL_LEVEL      = LEVEL_W'(255);

    // Pattern modes; the fourth code behaves as off
    typedef enum logic [MODE_W-1:0] {
        MODE_OFF       = 2'd0,
        MODE_HUE_CYCLE = 2'd1,
        MODE_FLASH     = 2'd2
    } t_mode;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_MODE = 3'd0,
        REG_BLINK_COLOR  = 3'd1,
        REG_BLINK_HALF   = 3'd2,
        REG_RAINBOW_STEP = 3'd3,
        REG_ACTIVE_LOW   = 3'd4
    } t_reg_idx;

    // One set of channel levels
    typedef struct packed {
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
    } t_rgb;

endpackage

// File: rtl/core/rgbled_adv_if.sv
// Tick channel: one transaction per millisecond tick or level query.
`timescale 1ns / 1ps

interface rgbled_adv_if;
    logic valid;
    logic ready;
    logic advance;

    modport source (output valid, output advance, input ready);
    modport sink   (input valid, input advance, output ready);
endinterface

// File: rtl/core/rgbled_lvl_if.sv
// Level channel: one transaction carries the three LED duty levels.
`timescale 1ns / 1ps

interface rgbled_lvl_if
    import rgbled_pkg::*;
    ();
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] red_level;
    logic [LEVEL_W-1:0] green_level;
    logic [LEVEL_W-1:0] blue_level;

    modport source (output valid, output red_level, output green_level, output blue_level,
                    input ready);
    modport sink   (input valid, input red_level, input green_level, input blue_level,
                    output ready);
endinterface

// File: rtl/core/rgb_led_pattern_generator_core.sv
// Top level of the RGB LED pattern generator: pattern state, HSV ramp and level register.
`timescale 1ns / 1ps

// Takes one tick transaction per clock while ready is high and returns one level
// transaction for each, in order. The accepted tick updates the pattern state
// (millisecond counter, hue, blink phase), and the levels derived from that state are
// then loaded into the output register. A stalled output holds one transaction in the
// output register and one in the state stage; ready drops only when both are full.
// Configuration writes take effect at the write edge; a write to the mode register
// restarts the pattern (count 0, hue 0, blink color shown first). Unused mode code 3
// behaves as off.
module rgb_led_pattern_generator_core
    import rgbled_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    rgbled_adv_if.sink           i_tick,
    rgbled_lvl_if.source         o_level
);

    // Configuration registers
    logic [MODE_W-1:0]  r_mode;
    logic [COLOR_W-1:0] r_color;
    logic [MS_W-1:0]    r_half_ms;
    logic [MS_W-1:0]    r_step_ms;
    logic               r_active_low;

    // Pattern state
    logic [MS_W-1:0]  r_ms_cnt,   n_ms_cnt;
    logic [HUE_W-1:0] r_hue,      n_hue;
    logic             r_phase_on, n_phase_on;

    // Pipeline control
    logic r_st_vld;
    logic r_out_vld;
    t_rgb r_lvl, n_lvl;

    logic out_free;
    logic st_move;
    logic in_acc;

    // Flow control: the state stage moves when it is empty or the output register can take it
    assign out_free     = !r_out_vld || o_level.ready;
    assign st_move      = !r_st_vld || out_free;
    assign i_tick.ready = st_move;
    assign in_acc       = i_tick.valid && st_move;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_W'(MODE_OFF);
            r_color      <= '0;
            r_half_ms    <= DEFAULT_HALF_MS;
            r_step_ms    <= RESET_STEP_MS;
            r_active_low <= 1'b1;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_PATTERN_MODE: r_mode       <= i_cfg_data[MODE_W-1:0];
                REG_BLINK_COLOR:  r_color      <= i_cfg_data[COLOR_W-1:0];
                REG_BLINK_HALF:   r_half_ms    <= i_cfg_data[MS_W-1:0];
                REG_RAINBOW_STEP: r_step_ms    <= i_cfg_data[MS_W-1:0];
                REG_ACTIVE_LOW:   r_active_low <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Period select and tick update
    logic [MS_W-1:0] period;
    logic [MS_W:0]   cnt_inc;
    logic            period_end;
    logic            tick_en;
    logic            restart;

    always_comb begin
        case (t_mode'(r_mode))
            MODE_HUE_CYCLE: period = (r_step_ms == '0) ? MS_W'(1) : r_step_ms;
            MODE_FLASH:     period = (r_half_ms == '0) ? DEFAULT_HALF_MS : r_half_ms;
            default:        period = MS_W'(1);
        endcase
        cnt_inc    = {1'b0, r_ms_cnt} + (MS_W+1)'(1);
        period_end = cnt_inc >= {1'b0, period};
        tick_en    = in_acc && i_tick.advance &&
                     (r_mode == MODE_W'(MODE_HUE_CYCLE) || r_mode == MODE_W'(MODE_FLASH));
        restart    = i_cfg_we && (i_cfg_idx == CFG_IDX_W'(REG_PATTERN_MODE));

        n_ms_cnt   = r_ms_cnt;
        n_hue      = r_hue;
        n_phase_on = r_phase_on;
        if (restart) begin
            n_ms_cnt   = '0;
            n_hue      = '0;
            n_phase_on = 1'b1;
        end else if (tick_en) begin
            if (period_end) begin
                n_ms_cnt = '0;
                if (r_mode == MODE_W'(MODE_HUE_CYCLE)) begin
                    n_hue = (r_hue >= HUE_LAST) ? '0 : r_hue + HUE_W'(1);
                end else begin
                    n_phase_on = !r_phase_on;
                end
            end else begin
                n_ms_cnt = cnt_inc[MS_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ms_cnt   <= '0;
            r_hue      <= '0;
            r_phase_on <= 1'b1;
            r_st_vld   <= 1'b0;
        end else begin
            r_ms_cnt   <= n_ms_cnt;
            r_hue      <= n_hue;
            r_phase_on <= n_phase_on;
            if (st_move) begin
                r_st_vld <= i_tick.valid;
            end
        end
    end

    // Hue to RGB: sector by compare chain, ramps are offset*17/4
    logic [2:0]          sector;
    logic [HUE_W-1:0]    hue_base;
    logic [5:0]          offset;
    logic [5:0]          offset_dn;
    logic [10:0]         up_prod;
    logic [10:0]         dn_prod;
    logic [LEVEL_W-1:0]  up;
    logic [LEVEL_W-1:0]  down;
    t_rgb                raw;

    always_comb begin
        if (r_hue < HUE_SECTOR) begin
            sector = 3'd0; hue_base = '0;
        end else if (r_hue < HUE_W'(120)) begin
            sector = 3'd1; hue_base = HUE_W'(60);
        end else if (r_hue < HUE_W'(180)) begin
            sector = 3'd2; hue_base = HUE_W'(120);
        end else if (r_hue < HUE_W'(240)) begin
            sector = 3'd3; hue_base = HUE_W'(180);
        end else if (r_hue < HUE_W'(300)) begin
            sector = 3'd4; hue_base = HUE_W'(240);
        end else begin
            sector = 3'd5; hue_base = HUE_W'(300);
        end
        offset    = 6'(r_hue - hue_base);
        offset_dn = 6'(HUE_SECTOR) - offset;
        up_prod   = {1'b0, offset, 4'b0} + 11'(offset);
        dn_prod   = {1'b0, offset_dn, 4'b0} + 11'(offset_dn);
        up        = up_prod[9:2];
        down      = dn_prod[9:2];

        raw = '0;
        case (t_mode'(r_mode))
            MODE_HUE_CYCLE: begin
                case (sector)
                    3'd0:    raw = '{red: FULL_LEVEL, green: up,         blue: '0};
                    3'd1:    raw = '{red: down,       green: FULL_LEVEL, blue: '0};
                    3'd2:    raw = '{red: '0,         green: FULL_LEVEL, blue: up};
                    3'd3:    raw = '{red: '0,         green: down,       blue: FULL_LEVEL};
                    3'd4:    raw = '{red: up,         green: '0,         blue: FULL_LEVEL};
                    default: raw = '{red: FULL_LEVEL, green: '0,         blue: down};
                endcase
            end
            MODE_FLASH: begin
                if (r_phase_on) begin
                    raw = r_color;
                end
            end
            default: raw = '0;
        endcase

        // Active-low drive inverts every level
        n_lvl = r_active_low ? ~raw : raw;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_st_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_st_vld) begin
            r_lvl <= n_lvl;
        end
    end

    assign o_level.valid       = r_out_vld;
    assign o_level.red_level   = r_lvl.red;
    assign o_level.green_level = r_lvl.green;
    assign o_level.blue_level  = r_lvl.blue;

endmodule

// File: rtl/core/rgbled_chk.sv
// Port-level checker for the RGB LED pattern generator, bound to the top level.
`timescale 1ns / 1ps

module rgbled_chk
    import rgbled_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_vld,
    input logic               i_in_rdy,
    input logic               i_out_vld,
    input logic               i_out_rdy,
    input logic [LEVEL_W-1:0] i_red,
    input logic [LEVEL_W-1:0] i_green,
    input logic [LEVEL_W-1:0] i_blue
);

    // A stalled result transaction keeps its levels
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_vld && !i_out_rdy |=> i_out_vld && $stable(i_red) && $stable(i_green)
                                    && $stable(i_blue))
        else $error("level transaction changed while stalled");

    // Input back-pressure only when a result is waiting
    a_rdy_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_rdy |-> i_out_vld)
        else $error("tick channel stalled with no result pending");

    // Every accepted tick is followed by a valid result on the level channel
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_vld && i_in_rdy |-> ##2 i_out_vld)
        else $error("no result two cycles after a tick transaction");

    // Reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_vld && i_in_rdy)
        else $error("pipeline not empty after reset");

endmodule

bind rgb_led_pattern_generator_core rgbled_chk u_rgbled_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_in_vld  (i_tick.valid),
    .i_in_rdy  (i_tick.ready),
    .i_out_vld (o_level.valid),
    .i_out_rdy (o_level.ready),
    .i_red     (o_level.red_level),
    .i_green   (o_level.green_level),
    .i_blue    (o_level.blue_level)
);

// File: tb/tb_top.sv
// Self-checking bench for the RGB LED pattern generator: directed table, then random phases.
`timescale 1ns / 1ps

module tb_top;
    import rgbled_pkg::*;

    localparam int STALL_LIMIT     = 2000;  // cycles with no transaction on either channel
    localparam int DRAIN_CYCLES    = 8;
    localparam int N_PHASES        = 9;
    localparam int SWEEP_PHASES    = 4;     // leading phases that run the hue through a wrap
    localparam int PHASE_ITEMS     = 100;

    // Mode code with no name in the package, and indexes past the register list
    localparam logic [MODE_W-1:0]    MODE_SPARE        = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IDX_SPARE_LO  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_IDX_SPARE_HI  = 3'd7;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_TICK,
        ROW_TICK_LIT
    } t_row_kind;

    typedef struct {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_DAT_W-1:0] data;
        logic                 adv;
        t_rgb                 lit;
    } t_row;

    // Directed table; literal levels only where they follow directly from mode and polarity
    localparam int N_ROWS = 39;
    t_row dir_rows [N_ROWS] = '{
        '{ROW_TICK_LIT, REG_PATTERN_MODE, 24'h000000, 1'b0, 24'hFFFFFF}, // off, inverted
        '{ROW_TICK_LIT, REG_PATTERN_MODE, 24'h000000, 1'b1, 24'hFFFFFF},
        '{ROW_WRITE,    REG_ACTIVE_LOW,   24'h000000, 1'b0, 24'h000000},
        '{ROW_TICK_LIT, REG_PATTERN_MODE, 24'h000000, 1'b1, 24'h000000},
        '{ROW_WRITE,    REG_RAINBOW_STEP, 24'h000001, 1'b0, 24'h000000},
        '{ROW_WRITE,    REG_PATTERN_MODE, 24'h000001, 1'b0, 24'h000000},
        '{ROW_TICK_LIT, REG_PATTERN_MODE, 24'h000000, 1'b0, 24'hFF0000}, // hue 0 is red
        '{ROW_TICK,     REG_PATTERN_MODE, 24'h000000, 1'b1, 24'h000000},
        '{ROW_TICK,     REG_PATTERN_MODE, 24'h000000, 1'b1, 24'h000000},
        '{ROW_WRITE,    REG_RAINBOW_STEP, 24'h000000, 1'b0, 24'h000000}, // zero step acts as one
        '{ROW_TICK,     REG_PATTERN_MODE, 24'h000000, 1'b1, 24'h000000},
        '{ROW_TICK,     REG_PATTERN_MODE, 24'h000000, 1'b0, 24'h000000},
        '{ROW_WRITE,    REG_RAINBOW_STEP, 24'h00FFFF, 1'b0, 24'h000000},
        '{ROW_TICK,     REG_PATTERN_MODE, 24'h000000, 1'b1, 24'h000000},
        '{ROW_WRITE,    REG_BLINK_COLOR,  24'hFFFFFF, 1'b0, 24'h000000},
        '{ROW_WRITE,    REG_BLINK_HALF,   24'h000000, 1'b0, 24'h000000}, // zero half -> 300
        '{ROW_WRITE,    REG_PATTERN_MODE, 24'h000002, 1'b0, 24'h000000},
        '{ROW_TICK_LIT, REG_PATTERN_MODE, 24'h000000, 1'b1, 24'hFFFFFF}, // color shown first
        '{ROW_TICK_LIT, REG_PATTERN_MODE, 24'h000000, 1'b0, 24'hFFFFFF},
        '{ROW_WRITE,    REG_BLINK_HALF,   24'h000001, 1'b0, 24'h000000},
        '{ROW_TICK_LIT, REG_PATTERN_MODE, 24'h000000, 1'b1, 24'h000000},
        '{ROW_TICK_LIT, REG_PATTERN_MODE, 24'h000000, 1'b1, 24'hFFFFFF},
        '{ROW_WRITE,    REG_BLINK_HALF,   24'h000005, 1'b0, 24'h000000},
        '{ROW_TICK,     REG_PATTERN_MODE, 24'h000000, 1'b1, 24'h000000},
        '{ROW_TICK,     REG_PATTERN_MODE, 24'h000000, 1'b1, 24'h000000},
        '{ROW_TICK,     REG_PATTERN_MODE, 24'h000000, 1'b1, 24'h000000},
        '{ROW_WRITE,    REG_BLINK_HALF,   24'h000002, 1'b0, 24'h000000}, // below running count
        '{ROW_TICK,     REG_PATTERN_MODE, 24'h000000, 1'b1, 24'h000000},
        '{ROW_WRITE,    REG_BLINK_COLOR,  24'h000000, 1'b0, 24'h000000},
        '{ROW_WRITE,    REG_BLINK_HALF,   24'hFFFFFF, 1'b0, 24'h000000},
        '{ROW_WRITE,    REG_IDX_SPARE_HI, 24'hFFFFFF, 1'b0, 24'h000000}, // ignored
        '{ROW_WRITE,    REG_IDX_SPARE_LO, 24'h000000, 1'b0, 24'h000000}, // ignored
        '{ROW_TICK,     REG_PATTERN_MODE, 24'h000000, 1'b1, 24'h000000},
        '{ROW_WRITE,    REG_PATTERN_MODE, 24'hFFFFFF, 1'b0, 24'h000000}, // spare mode code
        '{ROW_WRITE,    REG_ACTIVE_LOW,   24'hFFFFFF, 1'b0, 24'h000000},
        '{ROW_TICK_LIT, REG_PATTERN_MODE, 24'h000000, 1'b1, 24'hFFFFFF},
        '{ROW_TICK_LIT, REG_PATTERN_MODE, 24'h000000, 1'b0, 24'hFFFFFF},
        '{ROW_WRITE,    REG_PATTERN_MODE, 24'hFFFFFD, 1'b0, 24'h000000}, // masks to rainbow
        '{ROW_TICK,     REG_PATTERN_MODE, 24'h000000, 1'b1, 24'h000000}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;

    rgbled_adv_if tick_ch ();
    rgbled_lvl_if level_ch ();

    rgb_led_pattern_generator_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_tick     (tick_ch.sink),
        .o_level    (level_ch.source)
    );

    always #1 i_clk = ~i_clk;

    // Expected levels, oldest first
    t_rgb level_exp [$];
    int   errors = 0;
    int   quiet_cycles = 0;
    int   send_idle_pct = 0;
    int   rcv_stall_pct = 0;

    // Pattern state and register copies kept by the predictor
    logic [MODE_W-1:0]    mode_reg;
    logic [COLOR_W-1:0]   color_reg;
    logic [MS_W-1:0]      half_reg;
    logic [MS_W-1:0]      step_reg;
    logic                 invert_reg;
    logic [MS_W-1:0]      ms_count;
    logic [HUE_W-1:0]     hue_pos;
    logic                 blink_lit;

    task automatic reset_model();
        mode_reg   = MODE_OFF;
        color_reg  = '0;
        half_reg   = DEFAULT_HALF_MS;
        step_reg   = RESET_STEP_MS;
        invert_reg = 1'b1;
        ms_count   = '0;
        hue_pos    = '0;
        blink_lit  = 1'b1;
    endtask

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DAT_W-1:0] data);
        case (idx)
            REG_PATTERN_MODE: begin
                mode_reg  = data[MODE_W-1:0];
                ms_count  = '0;
                hue_pos   = '0;
                blink_lit = 1'b1;
            end
            REG_BLINK_COLOR:  color_reg  = data[COLOR_W-1:0];
            REG_BLINK_HALF:   half_reg   = data[MS_W-1:0];
            REG_RAINBOW_STEP: step_reg   = data[MS_W-1:0];
            REG_ACTIVE_LOW:   invert_reg = data[0];
            default: ;
        endcase
    endfunction

    // One millisecond against a period; a zero period acts as one
    function automatic logic count_period_end(input logic [MS_W-1:0] period);
        logic [MS_W:0] nxt;
        logic [MS_W:0] lim;
        nxt = {1'b0, ms_count} + (MS_W+1)'(1);
        lim = (period == '0) ? (MS_W+1)'(1) : {1'b0, period};
        if (nxt >= lim) begin
            ms_count = '0;
            return 1'b1;
        end
        ms_count = nxt[MS_W-1:0];
        return 1'b0;
    endfunction

    // Full-saturation hue wheel with integer ramps of 17/4 per degree
    function automatic t_rgb hue_color(input logic [HUE_W-1:0] h);
        int                 sector;
        int                 off;
        logic [LEVEL_W-1:0] up;
        logic [LEVEL_W-1:0] down;
        sector = h / HUE_SECTOR;
        off    = h % HUE_SECTOR;
        up     = LEVEL_W'((off * 17) >> 2);
        down   = LEVEL_W'(((HUE_SECTOR - off) * 17) >> 2);
        case (sector)
            0:       return {FULL_LEVEL, up, 8'd0};
            1:       return {down, FULL_LEVEL, 8'd0};
            2:       return {8'd0, FULL_LEVEL, up};
            3:       return {8'd0, down, FULL_LEVEL};
            4:       return {up, 8'd0, FULL_LEVEL};
            default: return {FULL_LEVEL, 8'd0, down};
        endcase
    endfunction

    // Levels produced by one tick, after updating the pattern state
    function automatic t_rgb predict_levels(input logic adv);
        t_rgb lv;
        lv = '0;
        if (mode_reg == MODE_HUE_CYCLE) begin
            if (adv && count_period_end(step_reg))
                hue_pos = (hue_pos == HUE_LAST) ? '0 : hue_pos + HUE_W'(1);
            lv = hue_color(hue_pos);
        end else if (mode_reg == MODE_FLASH) begin
            if (adv && count_period_end((half_reg == '0) ? DEFAULT_HALF_MS : half_reg))
                blink_lit = ~blink_lit;
            if (blink_lit)
                lv = t_rgb'(color_reg);
        end
        if (invert_reg) begin
            lv.red   = FULL_LEVEL - lv.red;
            lv.green = FULL_LEVEL - lv.green;
            lv.blue  = FULL_LEVEL - lv.blue;
        end
        return lv;
    endfunction

    function automatic logic [MS_W-1:0] pick_period();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return MS_W'($urandom);
            default: return MS_W'($urandom_range(1, 6));
        endcase
    endfunction

    // Tick driver: optional idle gap, then hold valid until accepted
    task automatic send_tick(input logic adv, input logic use_lit, input t_rgb lit);
        t_rgb lv;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge i_clk);
            tick_ch.valid = 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        tick_ch.valid   = 1'b1;
        tick_ch.advance = adv;
        @(posedge i_clk);
        while (!tick_ch.ready) @(posedge i_clk);
        lv = predict_levels(adv);
        level_exp.push_back(use_lit ? lit : lv);
    endtask

    // Stop sending and wait until every expected level transaction has arrived
    task automatic wait_drained();
        @(negedge i_clk);
        tick_ch.valid = 1'b0;
        while (level_exp.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        apply_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_idling(input int pattern);
        case (pattern)
            0:       begin send_idle_pct = 0;  rcv_stall_pct = 0;  end
            1:       begin send_idle_pct = 53; rcv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  rcv_stall_pct = 53; end
            default: begin send_idle_pct = 30; rcv_stall_pct = 30; end
        endcase
    endtask

    // Random register settings; the mode is rewritten (restart) only some of the time
    task automatic shuffle_config();
        int                   pick;
        logic [MODE_W-1:0]    code;
        logic [COLOR_W-1:0]   color;
        pick = $urandom_range(0, 7);
        code = (pick == 0) ? MODE_OFF : (pick == 1) ? MODE_SPARE :
               (pick < 5) ? MODE_HUE_CYCLE : MODE_FLASH;
        case ($urandom_range(0, 3))
            0:       color = '1;
            1:       color = '0;
            default: color = COLOR_W'($urandom);
        endcase
        write_reg(REG_BLINK_COLOR, color);
        write_reg(REG_BLINK_HALF, {8'($urandom), pick_period()});
        write_reg(REG_RAINBOW_STEP, {8'($urandom), pick_period()});
        write_reg(REG_ACTIVE_LOW, CFG_DAT_W'($urandom));
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_IDX_W'($urandom_range(REG_IDX_SPARE_LO, REG_IDX_SPARE_HI)),
                      CFG_DAT_W'($urandom));
        if ($urandom_range(0, 1) == 1)
            write_reg(REG_PATTERN_MODE, {22'($urandom), code});
    endtask

    // Receiver stalls
    initial begin
        level_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            level_ch.ready = ($urandom_range(0, 99) >= rcv_stall_pct);
        end
    end

    // Level checker: compare each accepted transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_rgb want;
        if (i_rst_n && level_ch.valid && level_ch.ready) begin
            if (level_exp.size() == 0) begin
                $error("unexpected level transaction: red %0d green %0d blue %0d",
                       level_ch.red_level, level_ch.green_level, level_ch.blue_level);
                errors++;
            end else begin
                want = level_exp.pop_front();
                if (level_ch.red_level !== want.red) begin
                    $error("red_level: expected %0d, actual %0d", want.red, level_ch.red_level);
                    errors++;
                end
                if (level_ch.green_level !== want.green) begin
                    $error("green_level: expected %0d, actual %0d",
                           want.green, level_ch.green_level);
                    errors++;
                end
                if (level_ch.blue_level !== want.blue) begin
                    $error("blue_level: expected %0d, actual %0d", want.blue, level_ch.blue_level);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (tick_ch.valid && tick_ch.ready) || (level_ch.valid && level_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Main sequence
    initial begin
        int adv_pct;
        tick_ch.valid   = 1'b0;
        tick_ch.advance = 1'b0;
        reset_model();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table, no idling
        set_idling(0);
        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_WRITE) begin
                wait_drained();
                write_reg(dir_rows[k].idx, dir_rows[k].data);
            end else begin
                send_tick(dir_rows[k].adv, dir_rows[k].kind == ROW_TICK_LIT, dir_rows[k].lit);
            end
        end

        // Random phases; the first few keep a one-ms rainbow running through the hue wrap
        for (int p = 0; p < N_PHASES; p++) begin
            wait_drained();
            set_idling(p % 4);
            if (p < SWEEP_PHASES) begin
                if (p == 0) begin
                    write_reg(REG_RAINBOW_STEP, CFG_DAT_W'(1));
                    write_reg(REG_PATTERN_MODE, CFG_DAT_W'(MODE_HUE_CYCLE));
                end
                write_reg(REG_ACTIVE_LOW, CFG_DAT_W'($urandom));
                adv_pct = 96;
            end else begin
                shuffle_config();
                adv_pct = 80;
            end
            repeat (PHASE_ITEMS)
                send_tick($urandom_range(0, 99) < adv_pct, 1'b0, '0);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && level_exp.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: files.f
rtl/core/rgbled_pkg.sv
rtl/core/rgbled_adv_if.sv
rtl/core/rgbled_lvl_if.sv
rtl/core/rgb_led_pattern_generator_core.sv
rtl/core/rgbled_chk.sv
tb/tb_top.sv
